// ----- design/mouse_packet_cursor_tracker_defines.svh -----
// Assertion macros for the mouse packet cursor tracker.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define MPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define MPCT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MPCT_ASSERT(lbl, prop, msg)
`define MPCT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ----- design/mpct_pkg.sv -----
// Shared types and constants of the mouse packet cursor tracker.
// No dependencies; used by the channel interfaces and the top level.
package mpct_pkg;

  // Field widths
  localparam int COORD_W   = 10;
  localparam int BYTE_W    = 8;
  localparam int BTN_W     = 3;
  localparam int SLOT_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_X_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_Y_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MENU_H  = 2'd2;

  // Register reset values
  localparam logic [COORD_W-1:0] X_LIMIT_RST = 10'd309;
  localparam logic [COORD_W-1:0] Y_LIMIT_RST = 10'd224;
  localparam logic [COORD_W-1:0] MENU_H_RST  = 10'd22;

  // Cursor start position
  localparam logic [COORD_W-1:0] POS_X_RST = 10'd160;
  localparam logic [COORD_W-1:0] POS_Y_RST = 10'd120;

  // Motion scaling; divisor in 1..8
  localparam int SPEED_DIVISOR = 2;
  localparam int RECIP_SHIFT   = 16;
  localparam int RECIP         = ((1 << RECIP_SHIFT) + SPEED_DIVISOR - 1) / SPEED_DIVISOR;

  // Note dot store
  localparam int DOT_CAPACITY = 256;

  // Status byte bits
  localparam int ST_LEFT  = 0;
  localparam int ST_SYNC  = 3;
  localparam int ST_XSIGN = 4;
  localparam int ST_YSIGN = 5;
  localparam int ST_XOVF  = 6;
  localparam int ST_YOVF  = 7;

  // Menu button geometry
  localparam int BTN_TOP     = 4;
  localparam int BTN_HEIGHT  = 16;
  localparam int BTN_WIDTH   = 40;
  localparam int BTN_SPACING = 6;
  localparam int BTN_FIRST_X = 4;
  localparam int BTN_COUNT   = 4;

  localparam logic [BTN_W-1:0] BTN_NONE = 3'd0;

  // Place of the next byte within a packet
  typedef enum logic [1:0] {
    BP_STATUS = 2'd0,
    BP_DX     = 2'd1,
    BP_DY     = 2'd2
  } byte_pos_t;

endpackage

// ----- design/mpct_if.sv -----
// Channel interfaces of the mouse packet cursor tracker: byte input,
// result output and configuration write. Depends on mpct_pkg.
interface mpct_in_if;
  logic                             valid;
  logic                             ready;
  logic [mpct_pkg::BYTE_W-1:0]      mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink   (input valid, input mouse_byte, output ready);
endinterface

interface mpct_out_if;
  logic                             valid;
  logic                             ready;
  logic [mpct_pkg::COORD_W-1:0]     cursor_x;
  logic [mpct_pkg::COORD_W-1:0]     cursor_y;
  logic                             left_pressed;
  logic [mpct_pkg::BTN_W-1:0]       button_index;
  logic                             dot_placed;
  logic [mpct_pkg::SLOT_W-1:0]      dot_slot;

  modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                  output button_index, output dot_placed, output dot_slot, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                  input button_index, input dot_placed, input dot_slot, output ready);
endinterface

interface mpct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mpct_pkg::CFG_IDX_W-1:0]   index;
  logic [mpct_pkg::COORD_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/mouse_packet_cursor_tracker.sv -----
// Top level of the mouse packet cursor tracker: packet assembly, motion
// scaling, cursor clamping, menu hit test and dot placement.
// Depends on mpct_pkg, mpct_if.sv and mouse_packet_cursor_tracker_defines.svh.

// The block takes one PS/2 mouse byte per cycle. Each accepted byte is
// captured in an input register at its accepting edge, and the packet work
// is done from that register into the result register once the result
// register is free or being emptied. Input is taken every cycle while the
// input register is empty or the result register is free or being
// emptied; a stalled result holds the byte in the input register. Bytes
// that lack bit 3 where a status byte is due, the first two bytes of each
// packet and overflow packets give no result. The configuration port
// takes a write every cycle and must only be used while no byte is in
// flight.

`include "mouse_packet_cursor_tracker_defines.svh"

module mouse_packet_cursor_tracker #(
  parameter int DOT_CAPACITY = mpct_pkg::DOT_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  mpct_in_if.sink           in_ch,
  mpct_out_if.source        out_ch,
  mpct_cfg_if.sink          cfg_ch
);

  localparam int CW     = mpct_pkg::COORD_W;
  localparam int CNT_W  = $clog2(DOT_CAPACITY + 1);
  localparam int MAG_W  = 9;
  localparam int PROD_W = MAG_W + mpct_pkg::RECIP_SHIFT + 1;
  localparam int SUM_W  = CW + 2;

  // Configuration registers
  logic [CW-1:0] x_limit_r, y_limit_r, menu_h_r;

  // Input register
  logic                          stage_v_r;
  logic [mpct_pkg::BYTE_W-1:0]   byte_r;

  // Packet and motion state
  mpct_pkg::byte_pos_t           byte_pos_r, byte_pos_nxt;
  logic [mpct_pkg::BYTE_W-1:0]   status_r, status_nxt;
  logic [mpct_pkg::BYTE_W-1:0]   dx_byte_r, dx_byte_nxt;
  logic signed [3:0]             rem_x_r, rem_x_nxt;
  logic signed [3:0]             rem_y_r, rem_y_nxt;
  logic [CW-1:0]                 pos_x_r, pos_x_nxt;
  logic [CW-1:0]                 pos_y_r, pos_y_nxt;
  logic                          last_left_r, last_left_nxt;
  logic [CNT_W-1:0]              dot_cnt_r, dot_cnt_nxt;

  // Result register
  logic                          out_v_r, out_v_nxt;
  logic [CW-1:0]                 out_x_r, out_x_nxt;
  logic [CW-1:0]                 out_y_r, out_y_nxt;
  logic                          out_press_r, out_press_nxt;
  logic [mpct_pkg::BTN_W-1:0]    out_btn_r, out_btn_nxt;
  logic                          out_dot_r, out_dot_nxt;
  logic [mpct_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  // Datapath signals
  logic                          out_free, go;
  logic signed [CW-1:0]          ax, ay, mx, my;
  logic [MAG_W-1:0]              mag_x, mag_y, q_x, q_y;
  logic [PROD_W-1:0]             prod_x, prod_y;
  logic [11:0]                   qd_x, qd_y;
  logic [2:0]                    rm_x, rm_y;
  logic signed [SUM_W-1:0]       sum_x, sum_y;
  logic [CW-1:0]                 cx, cy;
  logic [mpct_pkg::BTN_W-1:0]    btn;
  logic [CW-1:0]                 btn_left;
  logic                          left_btn, rise;

  // Handshakes: the input register advances whenever the result slot frees
  assign out_free     = !out_v_r || out_ch.ready;
  assign go           = stage_v_r && out_free;
  assign in_ch.ready  = !stage_v_r || out_free;
  assign cfg_ch.ready = 1'b1;

  // Accumulate and scale motion: truncate toward zero through a reciprocal
  always_comb begin
    ax = CW'($signed(rem_x_r)) + CW'($signed({status_r[mpct_pkg::ST_XSIGN], dx_byte_r}));
    ay = CW'($signed(rem_y_r)) + CW'($signed({status_r[mpct_pkg::ST_YSIGN], byte_r}));
    mag_x  = ax[CW-1] ? MAG_W'(-ax) : MAG_W'(ax);
    mag_y  = ay[CW-1] ? MAG_W'(-ay) : MAG_W'(ay);
    prod_x = PROD_W'(mag_x) * PROD_W'(mpct_pkg::RECIP);
    prod_y = PROD_W'(mag_y) * PROD_W'(mpct_pkg::RECIP);
    q_x    = prod_x[mpct_pkg::RECIP_SHIFT +: MAG_W];
    q_y    = prod_y[mpct_pkg::RECIP_SHIFT +: MAG_W];
    qd_x   = 12'(q_x) * 12'(mpct_pkg::SPEED_DIVISOR);
    qd_y   = 12'(q_y) * 12'(mpct_pkg::SPEED_DIVISOR);
    rm_x   = 3'(mag_x - qd_x[MAG_W-1:0]);
    rm_y   = 3'(mag_y - qd_y[MAG_W-1:0]);
    mx     = ax[CW-1] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    my     = ay[CW-1] ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
  end

  // Move and clamp the cursor; y runs opposite to the mouse
  always_comb begin
    sum_x = $signed({2'b00, pos_x_r}) + SUM_W'(mx);
    sum_y = $signed({2'b00, pos_y_r}) - SUM_W'(my);
    if (sum_x[SUM_W-1]) begin
      cx = '0;
    end else if (sum_x[SUM_W-2:0] > {1'b0, x_limit_r}) begin
      cx = x_limit_r;
    end else begin
      cx = sum_x[CW-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      cy = '0;
    end else if (sum_y[SUM_W-2:0] > {1'b0, y_limit_r}) begin
      cy = y_limit_r;
    end else begin
      cy = sum_y[CW-1:0];
    end
  end

  // Hit-test the four menu buttons
  always_comb begin
    btn      = mpct_pkg::BTN_NONE;
    btn_left = '0;
    if (cy >= CW'(mpct_pkg::BTN_TOP) &&
        cy < CW'(mpct_pkg::BTN_TOP + mpct_pkg::BTN_HEIGHT)) begin
      for (int k = 0; k < mpct_pkg::BTN_COUNT; k++) begin
        btn_left = CW'(mpct_pkg::BTN_FIRST_X +
                       k * (mpct_pkg::BTN_WIDTH + mpct_pkg::BTN_SPACING));
        if (cx >= btn_left && cx < btn_left + CW'(mpct_pkg::BTN_WIDTH)) begin
          btn = mpct_pkg::BTN_W'(k + 1);
        end
      end
    end
  end

  assign left_btn = status_r[mpct_pkg::ST_LEFT];
  assign rise     = left_btn && !last_left_r;

  // Next state: assemble packets and build the result
  always_comb begin
    byte_pos_nxt  = byte_pos_r;
    status_nxt    = status_r;
    dx_byte_nxt   = dx_byte_r;
    rem_x_nxt     = rem_x_r;
    rem_y_nxt     = rem_y_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    last_left_nxt = last_left_r;
    dot_cnt_nxt   = dot_cnt_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_press_nxt = out_press_r;
    out_btn_nxt   = out_btn_r;
    out_dot_nxt   = out_dot_r;
    out_slot_nxt  = out_slot_r;
    if (go) begin
      unique case (byte_pos_r)
        mpct_pkg::BP_DX: begin
          dx_byte_nxt  = byte_r;
          byte_pos_nxt = mpct_pkg::BP_DY;
        end
        mpct_pkg::BP_DY: begin
          byte_pos_nxt  = mpct_pkg::BP_STATUS;
          last_left_nxt = left_btn;
          if (!status_r[mpct_pkg::ST_XOVF] && !status_r[mpct_pkg::ST_YOVF]) begin
            rem_x_nxt     = ax[CW-1] ? -$signed({1'b0, rm_x}) : $signed({1'b0, rm_x});
            rem_y_nxt     = ay[CW-1] ? -$signed({1'b0, rm_y}) : $signed({1'b0, rm_y});
            pos_x_nxt     = cx;
            pos_y_nxt     = cy;
            out_v_nxt     = 1'b1;
            out_x_nxt     = cx;
            out_y_nxt     = cy;
            out_press_nxt = rise;
            out_btn_nxt   = rise ? btn : mpct_pkg::BTN_NONE;
            out_dot_nxt   = 1'b0;
            out_slot_nxt  = '0;
            // Drop a note dot below the menu bar while room remains
            if (rise && btn == mpct_pkg::BTN_NONE && cy >= menu_h_r &&
                dot_cnt_r < CNT_W'(DOT_CAPACITY)) begin
              out_dot_nxt  = 1'b1;
              out_slot_nxt = mpct_pkg::SLOT_W'(9'(dot_cnt_r));
              dot_cnt_nxt  = CNT_W'(dot_cnt_r + 1'b1);
            end
          end
        end
        default: begin
          // Wait for a status byte with the sync bit set
          if (byte_r[mpct_pkg::ST_SYNC]) begin
            status_nxt   = byte_r;
            byte_pos_nxt = mpct_pkg::BP_DX;
          end
        end
      endcase
    end
  end

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= mpct_pkg::X_LIMIT_RST;
      y_limit_r <= mpct_pkg::Y_LIMIT_RST;
      menu_h_r  <= mpct_pkg::MENU_H_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        mpct_pkg::CFG_IDX_X_LIMIT: x_limit_r <= cfg_ch.data;
        mpct_pkg::CFG_IDX_Y_LIMIT: y_limit_r <= cfg_ch.data;
        mpct_pkg::CFG_IDX_MENU_H:  menu_h_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stage_v_r <= 1'b1;
    end else if (go) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.mouse_byte;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= mpct_pkg::BP_STATUS;
      status_r    <= '0;
      dx_byte_r   <= '0;
      rem_x_r     <= '0;
      rem_y_r     <= '0;
      pos_x_r     <= mpct_pkg::POS_X_RST;
      pos_y_r     <= mpct_pkg::POS_Y_RST;
      last_left_r <= 1'b0;
      dot_cnt_r   <= '0;
      out_v_r     <= 1'b0;
    end else begin
      byte_pos_r  <= byte_pos_nxt;
      status_r    <= status_nxt;
      dx_byte_r   <= dx_byte_nxt;
      rem_x_r     <= rem_x_nxt;
      rem_y_r     <= rem_y_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      last_left_r <= last_left_nxt;
      dot_cnt_r   <= dot_cnt_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_press_r <= out_press_nxt;
    out_btn_r   <= out_btn_nxt;
    out_dot_r   <= out_dot_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.cursor_x     = out_x_r;
  assign out_ch.cursor_y     = out_y_r;
  assign out_ch.left_pressed = out_press_r;
  assign out_ch.button_index = out_btn_r;
  assign out_ch.dot_placed   = out_dot_r;
  assign out_ch.dot_slot     = out_slot_r;

  // Checks
  `MPCT_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_ch.valid, "result valid after reset")
  `MPCT_ASSERT(a_cursor_in_limits, out_ch.valid |-> (out_x_r <= x_limit_r && out_y_r <= y_limit_r), "cursor outside limits")
  `MPCT_ASSERT(a_btn_needs_press, out_ch.valid && out_btn_r != mpct_pkg::BTN_NONE |-> out_press_r, "button without press")
  `MPCT_ASSERT(a_dot_needs_free_press, out_ch.valid && out_dot_r |-> (out_press_r && out_btn_r == mpct_pkg::BTN_NONE), "dot on button or without press")
  `MPCT_ASSERT(a_rem_small, (5'(rem_x_r) < 5'(mpct_pkg::SPEED_DIVISOR)) && (5'(rem_x_r) > -5'(mpct_pkg::SPEED_DIVISOR)) && (5'(rem_y_r) < 5'(mpct_pkg::SPEED_DIVISOR)) && (5'(rem_y_r) > -5'(mpct_pkg::SPEED_DIVISOR)), "remainder out of range")
  `MPCT_ASSERT(a_dot_count_cap, $past(dot_cnt_r) <= CNT_W'(DOT_CAPACITY) |-> dot_cnt_r <= CNT_W'(DOT_CAPACITY), "dot count past capacity")

endmodule

// ----- verif/mouse_packet_cursor_tracker_tb.sv -----
// Self-checking testbench for the mouse packet cursor tracker: a scoreboard
// class predicts every cursor result from the accepted bytes and settings.
// Depends on mpct_pkg, mpct_if.sv and the mouse_packet_cursor_tracker top level.
module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  localparam int ITEM_TARGET   = 1150;
  localparam int CALM_ITEMS    = 150;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0]   COORD_MAX      = '1;

  typedef struct packed {
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic               left_pressed;
    logic [BTN_W-1:0]   button_index;
    logic               dot_placed;
    logic [SLOT_W-1:0]  dot_slot;
  } cursor_result_t;

  // Tracks packet assembly, motion and dot placement; holds expected results
  class cursor_scoreboard;
    logic [COORD_W-1:0] x_limit;
    logic [COORD_W-1:0] y_limit;
    logic [COORD_W-1:0] menu_h;
    byte_pos_t          pos;
    logic [BYTE_W-1:0]  status;
    logic [BYTE_W-1:0]  dx_byte;
    logic signed [7:0]  rem_x;
    logic signed [7:0]  rem_y;
    int                 pos_x;
    int                 pos_y;
    bit                 last_left;
    int                 dot_count;
    int                 mismatches;
    cursor_result_t     pending_cursor_q[$];

    function new();
      x_limit    = X_LIMIT_RST;
      y_limit    = Y_LIMIT_RST;
      menu_h     = MENU_H_RST;
      pos        = BP_STATUS;
      status     = '0;
      dx_byte    = '0;
      rem_x      = '0;
      rem_y      = '0;
      pos_x      = int'(POS_X_RST);
      pos_y      = int'(POS_Y_RST);
      last_left  = 1'b0;
      dot_count  = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_cursor_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        CFG_IDX_X_LIMIT: x_limit = data;
        CFG_IDX_Y_LIMIT: y_limit = data;
        CFG_IDX_MENU_H:  menu_h  = data;
        default: ;
      endcase
    endfunction

    function int clamp_axis(int v, int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
    endfunction

    function logic [BTN_W-1:0] hit_button(int x, int y);
      int left_col;
      if (y < BTN_TOP || y >= BTN_TOP + BTN_HEIGHT) return BTN_NONE;
      for (int k = 0; k < BTN_COUNT; k++) begin
        left_col = BTN_FIRST_X + k * (BTN_WIDTH + BTN_SPACING);
        if (x >= left_col && x < left_col + BTN_WIDTH) return BTN_W'(k + 1);
      end
      return BTN_NONE;
    endfunction

    // Advance the packet state by one accepted byte; queue a result on a full packet
    function void note_byte(logic [BYTE_W-1:0] b);
      int             dx;
      int             dy;
      int             ax;
      int             ay;
      int             mx;
      int             my;
      bit             left_btn;
      cursor_result_t r;
      if (pos == BP_STATUS) begin
        // drop bytes until one carries the sync bit
        if (b[ST_SYNC]) begin
          status = b;
          pos    = BP_DX;
        end
        return;
      end
      if (pos == BP_DX) begin
        dx_byte = b;
        pos     = BP_DY;
        return;
      end
      pos      = BP_STATUS;
      dx       = int'(dx_byte) - (status[ST_XSIGN] ? 256 : 0);
      dy       = int'(b) - (status[ST_YSIGN] ? 256 : 0);
      left_btn = status[ST_LEFT];

      // overflow packet: only the left button is tracked
      if (status[ST_XOVF] || status[ST_YOVF]) begin
        last_left = left_btn;
        return;
      end

      // scale motion, keep the remainders, invert y and clamp
      ax    = int'(rem_x) + dx;
      ay    = int'(rem_y) + dy;
      mx    = ax / SPEED_DIVISOR;
      my    = ay / SPEED_DIVISOR;
      rem_x = 8'(ax - mx * SPEED_DIVISOR);
      rem_y = 8'(ay - my * SPEED_DIVISOR);
      pos_x = clamp_axis(pos_x + mx, int'(x_limit));
      pos_y = clamp_axis(pos_y - my, int'(y_limit));

      r          = '0;
      r.cursor_x = COORD_W'(pos_x);
      r.cursor_y = COORD_W'(pos_y);
      if (left_btn && !last_left) begin
        r.left_pressed = 1'b1;
        r.button_index = hit_button(pos_x, pos_y);
        if (r.button_index == BTN_NONE && pos_y >= int'(menu_h) &&
            dot_count < DOT_CAPACITY) begin
          r.dot_placed = 1'b1;
          r.dot_slot   = SLOT_W'(dot_count);
          dot_count++;
        end
      end
      last_left = left_btn;
      pending_cursor_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(cursor_result_t got);
      cursor_result_t want;
      if (pending_cursor_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: x=%0d y=%0d",
                                  got.cursor_x, got.cursor_y));
        return;
      end
      want = pending_cursor_q.pop_front();
      if (got.cursor_x !== want.cursor_x)
        report_mismatch($sformatf("cursor_x %0d, want %0d", got.cursor_x, want.cursor_x));
      if (got.cursor_y !== want.cursor_y)
        report_mismatch($sformatf("cursor_y %0d, want %0d", got.cursor_y, want.cursor_y));
      if (got.left_pressed !== want.left_pressed)
        report_mismatch($sformatf("left_pressed %0b, want %0b",
                                  got.left_pressed, want.left_pressed));
      if (got.button_index !== want.button_index)
        report_mismatch($sformatf("button_index %0d, want %0d",
                                  got.button_index, want.button_index));
      if (got.dot_placed !== want.dot_placed)
        report_mismatch($sformatf("dot_placed %0b, want %0b", got.dot_placed, want.dot_placed));
      if (got.dot_slot !== want.dot_slot)
        report_mismatch($sformatf("dot_slot %0d, want %0d", got.dot_slot, want.dot_slot));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mpct_in_if  in_ch();
  mpct_out_if out_ch();
  mpct_cfg_if cfg_ch();

  cursor_scoreboard sb;
  bit               calm;
  int               n_sent;
  int               stall_cycles;
  int               idle_cycles;

  // Sync bytes, corner clamp, three buttons, overflow and extreme deltas
  logic [BYTE_W-1:0] opening_bytes [26] = '{
    8'h00, 8'hF7,
    8'h18, 8'h00, 8'hFF,
    8'h18, 8'h00, 8'hFF,
    8'h29, 8'h28, 8'hEC,
    8'hC8, 8'hFF, 8'hFF,
    8'h09, 8'h64, 8'h00,
    8'h08, 8'h00, 8'h00,
    8'h09, 8'h5C, 8'h00,
    8'h3F, 8'hFF, 8'h00
  };

  mouse_packet_cursor_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side in random bursts, except in the calm tail
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_cycles = $urandom_range(1, 16) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin : result_monitor
    cursor_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cursor_x     = out_ch.cursor_x;
      got.cursor_y     = out_ch.cursor_y;
      got.left_pressed = out_ch.left_pressed;
      got.button_index = out_ch.button_index;
      got.dot_placed   = out_ch.dot_placed;
      got.dot_slot     = out_ch.dot_slot;
      sb.check_result(got);
    end
  end

  // End the run when no channel has moved an item for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int bound(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Flip the left button most of the time so presses are frequent
  function automatic bit pick_left();
    return ($urandom_range(0, 9) < 7) ? !sb.last_left : sb.last_left;
  endfunction

  function automatic logic [BYTE_W-1:0] make_status(bit left, bit xneg, bit yneg, bit ovf);
    logic [BYTE_W-1:0] s;
    s           = '0;
    s[2:1]      = 2'($urandom_range(0, 3));  // right and middle buttons, ignored
    s[ST_SYNC]  = 1'b1;
    s[ST_LEFT]  = left;
    s[ST_XSIGN] = xneg;
    s[ST_YSIGN] = yneg;
    if (ovf) begin
      s[ST_XOVF] = 1'($urandom_range(0, 1));
      s[ST_YOVF] = !s[ST_XOVF] || ($urandom_range(0, 1) == 1);
    end
    return s;
  endfunction

  // Drive one byte, with an occasional random gap ahead of it outside the calm tail, and hold it until taken
  task automatic send_byte(logic [BYTE_W-1:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mouse_byte <= b;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    sb.note_byte(b);
    n_sent++;
  endtask

  task automatic send_packet(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] dxb,
                             logic [BYTE_W-1:0] dyb);
    send_byte(s);
    send_byte(dxb);
    send_byte(dyb);
  endtask

  // Build a packet that lands the cursor on (tx, ty) as far as one packet reaches
  task automatic send_aimed_packet(int tx, int ty);
    int mx;
    int my;
    int dx;
    int dy;
    mx = bound(tx - sb.pos_x, -127, 127);
    my = bound(sb.pos_y - ty, -127, 127);
    dx = bound(mx * SPEED_DIVISOR - int'(sb.rem_x), -256, 255);
    dy = bound(my * SPEED_DIVISOR - int'(sb.rem_y), -256, 255);
    send_packet(make_status(pick_left(), dx < 0, dy < 0, 1'b0), 8'(dx), 8'(dy));
  endtask

  task automatic send_random_move();
    int dx;
    int dy;
    dx = $urandom_range(0, 511) - 256;
    dy = $urandom_range(0, 511) - 256;
    send_packet(make_status(pick_left(), dx < 0, dy < 0, 1'b0), 8'(dx), 8'(dy));
  endtask

  // Hold off the sender until every expected result is out and the pipe is empty
  task automatic settle_block();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [COORD_W-1:0] pick_setting();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_MAX;
      default: return COORD_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Fixed corner settings first, then random ones
  task automatic apply_setting(int k);
    logic [COORD_W-1:0] xl;
    logic [COORD_W-1:0] yl;
    logic [COORD_W-1:0] mh;
    case (k)
      0: begin
        xl = COORD_MAX;
        yl = COORD_MAX;
        mh = '0;
      end
      1: begin
        xl = '0;
        yl = '0;
        mh = '0;
      end
      2: begin
        xl = X_LIMIT_RST;
        yl = Y_LIMIT_RST;
        mh = COORD_MAX;
      end
      3: begin
        xl = 10'd100;
        yl = 10'd50;
        mh = MENU_H_RST;
      end
      default: begin
        xl = pick_setting();
        yl = pick_setting();
        mh = pick_setting();
      end
    endcase
    write_reg(CFG_IDX_X_LIMIT, xl);
    write_reg(CFG_IDX_UNUSED, COORD_W'($urandom_range(0, 1023)));
    write_reg(CFG_IDX_Y_LIMIT, yl);
    write_reg(CFG_IDX_MENU_H, mh);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int setting;
    int phase_start;
    int phase_len;
    int calm_start;
    int pick;
    int tx;
    int ty;

    in_ch.valid      = 1'b0;
    in_ch.mouse_byte = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    calm             = 1'b0;
    n_sent           = 0;
    stall_cycles     = 0;
    idle_cycles      = 0;
    sb               = new();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening with the reset settings
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    settle_block();

    // Random traffic in phases, each under new settings
    setting     = 0;
    phase_start = n_sent;
    phase_len   = $urandom_range(120, 300);
    calm_start  = 0;
    while (!(calm && n_sent - calm_start >= CALM_ITEMS)) begin
      if (!calm && n_sent - phase_start >= phase_len) begin
        settle_block();
        apply_setting(setting);
        setting++;
        phase_start = n_sent;
        phase_len   = $urandom_range(120, 300);
      end

      pick = $urandom_range(0, 99);
      if (pick == 0) begin
        settle_block();
      end else if (pick < 10) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 15) begin
        send_packet(make_status(pick_left(), $urandom_range(0, 1) == 1,
                                $urandom_range(0, 1) == 1, 1'b1),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 50) begin
        // aim at the menu buttons, their edges and the gaps between them
        tx = $urandom_range(0, BTN_FIRST_X + BTN_COUNT * (BTN_WIDTH + BTN_SPACING) + 4);
        ty = $urandom_range(BTN_TOP - 2, BTN_TOP + BTN_HEIGHT + 1);
        send_aimed_packet(tx, ty);
      end else if (pick < 60) begin
        // aim just around the menu bar boundary
        tx = $urandom_range(0, int'(sb.x_limit) + 4);
        ty = int'(sb.menu_h) + $urandom_range(0, 2) - 1;
        send_aimed_packet(tx, ty);
      end else if (pick < 80) begin
        tx = $urandom_range(0, int'(sb.x_limit) + 20);
        ty = $urandom_range(0, int'(sb.y_limit) + 20);
        send_aimed_packet(tx, ty);
      end else begin
        send_random_move();
      end

      // go calm once enough traffic has run
      if (!calm && n_sent >= ITEM_TARGET - CALM_ITEMS) begin
        calm       = 1'b1;
        calm_start = n_sent;
      end
    end

    settle_block();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/mpct_pkg.sv
design/mpct_if.sv
design/mouse_packet_cursor_tracker.sv
verif/mouse_packet_cursor_tracker_tb.sv
